### design/dprhc_pkg.sv
package dprhc_pkg;

    // Command codes on s_func; unused codes act as no command
    localparam logic [2:0] FUNC_NONE   = 3'd0;
    localparam logic [2:0] FUNC_START  = 3'd1;
    localparam logic [2:0] FUNC_STOP   = 3'd2;
    localparam logic [2:0] FUNC_HEATER = 3'd3;
    localparam logic [2:0] FUNC_DUTY   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_STEP      = 2'd2;

    localparam int PWM_BITS_DEF = 9;
    localparam int STEP_W       = 9;
    localparam int PCT_W        = 7;

    localparam logic [31:0]       TIMEOUT_RESET   = 32'd3600000;
    localparam logic signed [15:0] THRESHOLD_RESET = 16'sd0;
    localparam logic [STEP_W-1:0] STEP_RESET      = 9'd16;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // x / 100 == (x * PCT_RECIP) >> RECIP_SHIFT for x below about 14e6,
    // which covers 65535 * 100
    localparam int          RECIP_SHIFT = 30;
    localparam logic [63:0] PCT_RECIP   = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;

    typedef struct packed {
        logic [31:0]        timeout_ms;
        logic signed [15:0] threshold;
        logic [STEP_W-1:0]  step;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic       sel;       // command addresses this channel
        logic       heater_req;
    } cmd_t;

    typedef struct packed {
        logic heater;
        logic active;
        logic motor;
        logic advance;
    } chan_stat_t;

endpackage

### design/dprhc_chan.sv
module dprhc_chan #(
    parameter int PWM_BITS = dprhc_pkg::PWM_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     upd,
    input  dprhc_pkg::cfg_t          cfg,
    input  dprhc_pkg::cmd_t          cmd,
    input  logic [PWM_BITS-1:0]      cmd_duty,
    input  logic [31:0]              now_ms,
    input  logic signed [15:0]       humidity_diff,
    output logic [PWM_BITS-1:0]      duty_next,
    output dprhc_pkg::chan_stat_t    stat_next
);
    import dprhc_pkg::*;

    localparam int CW = (PWM_BITS > STEP_W) ? PWM_BITS : STEP_W;
    localparam logic [PWM_BITS-1:0] DUTY_MAX = {PWM_BITS{1'b1}};

    typedef logic [CW-1:0] wide_t;

    logic                active_reg, active_next;
    logic                motor_reg, motor_next;
    logic                heater_reg, heater_next;
    logic [31:0]         start_reg, start_next;
    logic [PWM_BITS-1:0] duty_reg;
    logic [PWM_BITS-1:0] target_reg, target_next;
    logic                adv;

    wide_t cur_w, tgt_w, step_w, gap, sum, dif;

    always_comb begin
        active_next = active_reg;
        motor_next  = motor_reg;
        heater_next = heater_reg;
        start_next  = start_reg;
        target_next = target_reg;
        adv         = 1'b0;

        if (cmd.sel) begin
            unique case (cmd.func)
                FUNC_START: begin
                    active_next = 1'b1;
                    motor_next  = 1'b1;
                    heater_next = 1'b1;
                    start_next  = now_ms;
                    target_next = DUTY_MAX;
                end
                FUNC_STOP: begin
                    active_next = 1'b0;
                    motor_next  = 1'b0;
                    heater_next = 1'b0;
                    start_next  = '0;
                    target_next = '0;
                end
                FUNC_HEATER: heater_next = cmd.heater_req;
                FUNC_DUTY:   target_next = cmd_duty;
                default: ;
            endcase
        end

        if (active_next) begin
            if (humidity_diff < cfg.threshold) begin
                active_next = 1'b0;
                adv         = 1'b1;
            end else if ((now_ms - start_next) >= cfg.timeout_ms) begin
                active_next = 1'b0;
                motor_next  = 1'b0;
                heater_next = 1'b0;
                start_next  = '0;
                target_next = '0;
                adv         = 1'b1;
            end
        end

        // ramp toward target, landing on it when within one step
        cur_w  = wide_t'(duty_reg);
        tgt_w  = wide_t'(target_next);
        step_w = wide_t'(cfg.step);
        sum    = cur_w + step_w;
        dif    = cur_w - step_w;
        gap    = (cur_w < tgt_w) ? (tgt_w - cur_w) : (cur_w - tgt_w);
        if (cur_w == tgt_w || gap <= step_w) begin
            duty_next = target_next;
        end else if (cur_w < tgt_w) begin
            duty_next = sum[PWM_BITS-1:0];
        end else begin
            duty_next = dif[PWM_BITS-1:0];
        end

        stat_next.heater  = heater_next;
        stat_next.active  = active_next;
        stat_next.motor   = motor_next;
        stat_next.advance = adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            motor_reg  <= 1'b0;
            heater_reg <= 1'b0;
            start_reg  <= '0;
            duty_reg   <= '0;
            target_reg <= '0;
        end else if (upd) begin
            active_reg <= active_next;
            motor_reg  <= motor_next;
            heater_reg <= heater_next;
            start_reg  <= start_next;
            duty_reg   <= duty_next;
            target_reg <= target_next;
        end
    end

endmodule

### design/dual_pwm_ramp_heater_controller.sv
// Two-channel motor PWM and heater relay controller with soft-start duty ramp.
// Every input transaction is one control pass: an optional command (start,
// stop, heater set, set duty percent) for the addressed channel, then a dry
// check and a safety timeout on each active channel, then each duty steps
// toward its target by at most ramp_step. Each pass yields exactly one result
// transaction with both duties, all flags and the count of advance events.
// Throughput is one transaction per clock unless the result stalls: the percent
// clamp and the /100 scaling (a constant reciprocal multiply) happen ahead of the
// input register, and the per-channel command, checks and ramp sit between the
// input register and the result register, which drives m_valid.
// The result register decouples the two sides; s_ready drops only while both
// the input register and a stalled result are full. Configuration writes
// (cfg_index 0 timeout, 1 dry threshold, 2 ramp step; 3 is ignored) are
// always ready and should only be issued while the block is idle.
module dual_pwm_ramp_heater_controller #(
    parameter int PWM_BITS = dprhc_pkg::PWM_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_func,
    input  logic                s_channel,
    input  logic                s_heater_request,
    input  logic signed [15:0]  s_duty_percent,
    input  logic [31:0]         s_now_ms,
    input  logic signed [15:0]  s_humidity_diff_a,
    input  logic signed [15:0]  s_humidity_diff_b,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [PWM_BITS-1:0] m_duty_a,
    output logic [PWM_BITS-1:0] m_duty_b,
    output logic                m_heater_a,
    output logic                m_heater_b,
    output logic                m_active_a,
    output logic                m_active_b,
    output logic                m_motor_on_a,
    output logic                m_motor_on_b,
    output logic [1:0]          m_advance_count
);
    import dprhc_pkg::*;

    localparam logic [PWM_BITS-1:0] DUTY_MAX = {PWM_BITS{1'b1}};
    // product width: (DUTY_MAX * pct / 100) < 2^PWM_BITS after the shift
    localparam int PW = RECIP_SHIFT + PWM_BITS;
    localparam logic [63:0] SCALE = 64'(DUTY_MAX) * PCT_RECIP;

    // ---------------- configuration registers ----------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
            cfg_reg.threshold  <= THRESHOLD_RESET;
            cfg_reg.step       <= STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TIMEOUT:   cfg_reg.timeout_ms <= cfg_data;
                CFG_THRESHOLD: cfg_reg.threshold  <= cfg_data[15:0];
                CFG_STEP:      cfg_reg.step       <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- percent clamp and scale (ahead of input reg) ----------------
    logic [PCT_W-1:0] pct_clamp;
    logic [PW-1:0]    scaled;

    always_comb begin
        if (s_duty_percent[15]) begin
            pct_clamp = '0;
        end else if (s_duty_percent > 16'sd100) begin
            pct_clamp = PCT_MAX;
        end else begin
            pct_clamp = s_duty_percent[PCT_W-1:0];
        end
        // floor(DUTY_MAX * pct / 100) via reciprocal, exact over the clamped range
        scaled = PW'(pct_clamp) * PW'(SCALE);
    end

    // ---------------- input register ----------------
    logic                in_vld_reg;
    logic [2:0]          func_reg;
    logic                chan_reg;
    logic                heat_req_reg;
    logic [PWM_BITS-1:0] cmd_duty_reg;
    logic [31:0]         now_reg;
    logic signed [15:0]  diff_a_reg;
    logic signed [15:0]  diff_b_reg;
    logic                fire;

    // a pass executes when the result register is free or being drained
    assign fire    = in_vld_reg && (!m_valid || m_ready);
    assign s_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg     <= s_func;
            chan_reg     <= s_channel;
            heat_req_reg <= s_heater_request;
            cmd_duty_reg <= scaled[PW-1 -: PWM_BITS];
            now_reg      <= s_now_ms;
            diff_a_reg   <= s_humidity_diff_a;
            diff_b_reg   <= s_humidity_diff_b;
        end
    end

    // ---------------- per-channel pass ----------------
    cmd_t                cmd_a, cmd_b;
    logic [PWM_BITS-1:0] duty_a_next, duty_b_next;
    chan_stat_t          stat_a, stat_b;

    always_comb begin
        cmd_a.func       = func_reg;
        cmd_a.heater_req = heat_req_reg;
        cmd_a.sel        = !chan_reg;
        cmd_b.func       = func_reg;
        cmd_b.heater_req = heat_req_reg;
        cmd_b.sel        = chan_reg;
    end

    dprhc_chan #(
        .PWM_BITS (PWM_BITS)
    ) u_chan_a (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (fire),
        .cfg           (cfg_reg),
        .cmd           (cmd_a),
        .cmd_duty      (cmd_duty_reg),
        .now_ms        (now_reg),
        .humidity_diff (diff_a_reg),
        .duty_next     (duty_a_next),
        .stat_next     (stat_a)
    );

    dprhc_chan #(
        .PWM_BITS (PWM_BITS)
    ) u_chan_b (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd           (fire),
        .cfg           (cfg_reg),
        .cmd           (cmd_b),
        .cmd_duty      (cmd_duty_reg),
        .now_ms        (now_reg),
        .humidity_diff (diff_b_reg),
        .duty_next     (duty_b_next),
        .stat_next     (stat_b)
    );

    // ---------------- result register ----------------
    logic out_vld_reg;

    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_duty_a        <= duty_a_next;
            m_duty_b        <= duty_b_next;
            m_heater_a      <= stat_a.heater;
            m_heater_b      <= stat_b.heater;
            m_active_a      <= stat_a.active;
            m_active_b      <= stat_b.active;
            m_motor_on_a    <= stat_a.motor;
            m_motor_on_b    <= stat_b.motor;
            m_advance_count <= 2'(stat_a.advance) + 2'(stat_b.advance);
        end
    end

endmodule

### sim/tb.sv
module tb;
    import dprhc_pkg::*;

    // Directed and random test of dual_pwm_ramp_heater_controller.
    // The driver offers control passes from pass_q; at each accepted input
    // transaction a cycle-level model of both channels computes the expected
    // status word, which waits in status_q until the monitor pulls the matching
    // result transaction and compares it field by field.

    localparam int DUTY_FULL  = (1 << PWM_BITS_DEF) - 1;
    localparam int QUIET_MAX  = 1000;  // cycles without any transaction
    localparam int HOLD_AT    = 200;   // result count that starts the long stall
    localparam int HOLD_LEN   = 40;
    localparam int DRAIN_WAIT = 4;     // lets the input and result registers drain, plus margin

    // index 3 is decoded by nothing; written once to show it is harmless
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // one control pass as offered on the s_ channel
    typedef struct {
        logic [2:0]         func;
        logic               channel;
        logic               heater_req;
        logic signed [15:0] pct;
        logic [31:0]        now;
        logic signed [15:0] hum_a;
        logic signed [15:0] hum_b;
    } pass_t;

    // one status word as returned on the m_ channel
    typedef struct packed {
        logic [8:0] duty_a;
        logic [8:0] duty_b;
        logic       heater_a;
        logic       heater_b;
        logic       active_a;
        logic       active_b;
        logic       motor_a;
        logic       motor_b;
        logic [1:0] advances;
    } status_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_TIMEOUT;
    logic [31:0]        cfg_data = '0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = FUNC_NONE;
    logic               s_channel = 1'b0;
    logic               s_heater_request = 1'b0;
    logic signed [15:0] s_duty_percent = '0;
    logic [31:0]        s_now_ms = '0;
    logic signed [15:0] s_humidity_diff_a = '0;
    logic signed [15:0] s_humidity_diff_b = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [8:0]         m_duty_a;
    logic [8:0]         m_duty_b;
    logic               m_heater_a;
    logic               m_heater_b;
    logic               m_active_a;
    logic               m_active_b;
    logic               m_motor_on_a;
    logic               m_motor_on_b;
    logic [1:0]         m_advance_count;

    dual_pwm_ramp_heater_controller u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_channel         (s_channel),
        .s_heater_request  (s_heater_request),
        .s_duty_percent    (s_duty_percent),
        .s_now_ms          (s_now_ms),
        .s_humidity_diff_a (s_humidity_diff_a),
        .s_humidity_diff_b (s_humidity_diff_b),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_duty_a          (m_duty_a),
        .m_duty_b          (m_duty_b),
        .m_heater_a        (m_heater_a),
        .m_heater_b        (m_heater_b),
        .m_active_a        (m_active_a),
        .m_active_b        (m_active_b),
        .m_motor_on_a      (m_motor_on_a),
        .m_motor_on_b      (m_motor_on_b),
        .m_advance_count   (m_advance_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Channel model: register copies and per-channel state
    // ---------------------------------------------------------------
    logic [31:0]        cfg_timeout = TIMEOUT_RESET;
    logic signed [15:0] cfg_thr     = THRESHOLD_RESET;
    logic [8:0]         cfg_step    = STEP_RESET;

    logic       ch_active [2] = '{1'b0, 1'b0};
    logic       ch_motor  [2] = '{1'b0, 1'b0};
    logic       ch_heater [2] = '{1'b0, 1'b0};
    logic [31:0] ch_start_ms [2] = '{32'd0, 32'd0};
    logic [8:0] ch_duty   [2] = '{9'd0, 9'd0};
    logic [8:0] ch_target [2] = '{9'd0, 9'd0};

    // stop and safety timeout both drop the channel completely
    function automatic void power_down(int c);
        ch_active[c]   = 1'b0;
        ch_motor[c]    = 1'b0;
        ch_heater[c]   = 1'b0;
        ch_target[c]   = '0;
        ch_start_ms[c] = '0;
    endfunction

    function automatic status_t predict_pass(pass_t p);
        status_t            r;
        int                 ch;
        int                 pct;
        int                 cur;
        int                 tgt;
        int                 step;
        logic [1:0]         adv;
        logic signed [15:0] hum [2];

        ch     = int'(p.channel);
        adv    = '0;
        hum[0] = p.hum_a;
        hum[1] = p.hum_b;
        step   = int'(cfg_step);

        // command first; codes 5..7 fall through as no command
        case (p.func)
            FUNC_START: begin
                ch_active[ch]   = 1'b1;
                ch_motor[ch]    = 1'b1;
                ch_heater[ch]   = 1'b1;
                ch_start_ms[ch] = p.now;
                ch_target[ch]   = 9'(DUTY_FULL);
            end
            FUNC_STOP:   power_down(ch);
            FUNC_HEATER: ch_heater[ch] = p.heater_req;
            FUNC_DUTY: begin
                pct = int'(p.pct);
                if (pct < 0)
                    pct = 0;
                if (pct > 100)
                    pct = 100;
                ch_target[ch] = 9'((DUTY_FULL * pct) / 100);
            end
            default: ;
        endcase

        // dry check, then timeout only if still active; elapsed time wraps
        for (int k = 0; k < 2; k++) begin
            if (ch_active[k]) begin
                if (hum[k] < cfg_thr) begin
                    ch_active[k] = 1'b0;
                    adv++;
                end
                if (ch_active[k] && (p.now - ch_start_ms[k]) >= cfg_timeout) begin
                    power_down(k);
                    adv++;
                end
            end
        end

        // soft ramp, landing exactly on the target
        for (int k = 0; k < 2; k++) begin
            cur = int'(ch_duty[k]);
            tgt = int'(ch_target[k]);
            if (cur < tgt)
                cur = (tgt - cur <= step) ? tgt : cur + step;
            else if (cur > tgt)
                cur = (cur - tgt <= step) ? tgt : cur - step;
            ch_duty[k] = 9'(cur);
        end

        r.duty_a   = ch_duty[0];
        r.duty_b   = ch_duty[1];
        r.heater_a = ch_heater[0];
        r.heater_b = ch_heater[1];
        r.active_a = ch_active[0];
        r.active_b = ch_active[1];
        r.motor_a  = ch_motor[0];
        r.motor_b  = ch_motor[1];
        r.advances = adv;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Shared bookkeeping
    // ---------------------------------------------------------------
    pass_t       pass_q[$];       // passes not yet offered
    status_t     status_q[$];     // predicted status words, oldest first
    int unsigned passes_queued   = 0;
    int unsigned results_checked = 0;
    int unsigned errors          = 0;
    int unsigned send_gap_max    = 0;
    int unsigned recv_gap_max    = 0;
    logic [31:0] wall_ms         = '0;

    // ---------------------------------------------------------------
    // Driver: one pass per transaction, random gap after each
    // ---------------------------------------------------------------
    pass_t       on_bus;
    int unsigned send_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            // accepted at this edge: model sees it in acceptance order
            if (s_valid && s_ready)
                status_q.push_back(predict_pass(on_bus));

            if (s_valid && !s_ready) begin
                // stalled: hold valid and payload
            end else if (send_wait != 0) begin
                s_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pass_q.size() != 0) begin
                on_bus             = pass_q.pop_front();
                s_func            <= on_bus.func;
                s_channel         <= on_bus.channel;
                s_heater_request  <= on_bus.heater_req;
                s_duty_percent    <= on_bus.pct;
                s_now_ms          <= on_bus.now;
                s_humidity_diff_a <= on_bus.hum_a;
                s_humidity_diff_b <= on_bus.hum_b;
                s_valid           <= 1'b1;
                send_wait         <= $urandom_range(0, send_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result transaction, random back-pressure
    // ---------------------------------------------------------------
    int unsigned recv_wait = 0;

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        status_t     want;
        int unsigned w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            w = recv_wait;
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: expected none, got duty %0d/%0d",
                             $time, m_duty_a, m_duty_b);
                end else begin
                    want = status_q.pop_front();
                    check_field("duty_a",        32'(want.duty_a),   32'(m_duty_a));
                    check_field("duty_b",        32'(want.duty_b),   32'(m_duty_b));
                    check_field("heater_a",      32'(want.heater_a), 32'(m_heater_a));
                    check_field("heater_b",      32'(want.heater_b), 32'(m_heater_b));
                    check_field("active_a",      32'(want.active_a), 32'(m_active_a));
                    check_field("active_b",      32'(want.active_b), 32'(m_active_b));
                    check_field("motor_on_a",    32'(want.motor_a),  32'(m_motor_on_a));
                    check_field("motor_on_b",    32'(want.motor_b),  32'(m_motor_on_b));
                    check_field("advance_count", 32'(want.advances), 32'(m_advance_count));
                end
                results_checked++;
                w = $urandom_range(0, recv_gap_max);
                // one long hold-off so the pipeline fills and s_ready drops
                if (results_checked == HOLD_AT)
                    w = HOLD_LEN;
            end
            if (w != 0) begin
                m_ready   <= 1'b0;
                recv_wait <= w - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any transaction means a hang
    // ---------------------------------------------------------------
    int unsigned quiet = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic pass_t mk_pass(logic [2:0] func, logic ch, logic req, int pct,
                                      logic [31:0] now, int ha, int hb);
        pass_t p;
        p.func       = func;
        p.channel    = ch;
        p.heater_req = req;
        p.pct        = 16'(pct);
        p.now        = now;
        p.hum_a      = 16'(ha);
        p.hum_b      = 16'(hb);
        return p;
    endfunction

    task automatic queue_pass(input pass_t p);
        pass_q.push_back(p);
        passes_queued++;
    endtask

    // mostly just above the dry threshold so channels stay active a while
    function automatic logic signed [15:0] rand_hum();
        int v;
        if ($urandom_range(0, 5) == 0)
            return 16'($urandom);
        v = int'(cfg_thr) + int'($urandom_range(0, 3000)) - 60;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic pass_t rand_pass();
        pass_t       p;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            p.func = FUNC_START;
        else if (r < 22)
            p.func = FUNC_STOP;
        else if (r < 32)
            p.func = FUNC_HEATER;
        else if (r < 50)
            p.func = FUNC_DUTY;
        else if (r < 90)
            p.func = FUNC_NONE;
        else
            p.func = 3'($urandom_range(5, 7));
        p.channel    = 1'($urandom);
        p.heater_req = 1'($urandom);
        if ($urandom_range(0, 9) < 7)
            p.pct = 16'(int'($urandom_range(0, 120)) - 10);
        else
            p.pct = 16'($urandom);
        // time mostly creeps forward; now and then it jumps anywhere
        if ($urandom_range(0, 49) == 0)
            wall_ms = $urandom;
        else
            wall_ms = wall_ms + $urandom_range(0, 400);
        p.now   = wall_ms;
        p.hum_a = rand_hum();
        p.hum_b = rand_hum();
        return p;
    endfunction

    task automatic queue_random(input int unsigned n);
        repeat (n) queue_pass(rand_pass());
    endtask

    // register write; model copy updates at the accepting edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIMEOUT:   cfg_timeout = val;
            CFG_THRESHOLD: cfg_thr     = val[15:0];
            CFG_STEP:      cfg_step    = val[8:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // upper data bits are random: the block must ignore them
    task automatic set_config(input logic [31:0] tmo, input int thr, input int step);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_THRESHOLD, {16'($urandom), 16'(thr)});
        write_reg(CFG_STEP, {23'($urandom), 9'(step)});
    endtask

    // every queued pass has come back, then let the pipeline settle
    task automatic wait_idle();
        while (results_checked != passes_queued)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed passes under reset settings: timeout 3600000, threshold 0,
        // step 16
        send_gap_max = 1;
        recv_gap_max = 1;
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0,      32'd0, 0, 0));
        queue_pass(mk_pass(FUNC_START,  0, 0, 0,      32'd0, 256, 256));
        queue_pass(mk_pass(FUNC_DUTY,   0, 0, 100,    32'd10, 256, 256));
        queue_pass(mk_pass(FUNC_DUTY,   0, 0, -32768, 32'd20, 256, 256));
        queue_pass(mk_pass(FUNC_DUTY,   0, 0, 32767,  32'd30, 256, 256));
        queue_pass(mk_pass(FUNC_DUTY,   1, 0, 50,     32'd40, 256, 256));
        queue_pass(mk_pass(FUNC_HEATER, 0, 0, 0,      32'd50, 256, 256));
        queue_pass(mk_pass(FUNC_HEATER, 1, 1, 0,      32'd60, 256, 256));
        queue_pass(mk_pass(FUNC_START,  1, 0, 0,      32'd1000, 256, 256));
        // unused codes behave as no command
        queue_pass(mk_pass(3'd5, 1, 1, -1,   32'd1100, 256, 256));
        queue_pass(mk_pass(3'd6, 0, 1, 75,   32'd1200, 256, 256));
        queue_pass(mk_pass(3'd7, 1, 1, 100,  32'd1300, 32767, 32767));
        // channel 0 goes dry
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'd1400, -1, 256));
        queue_pass(mk_pass(FUNC_STOP,   0, 0, 0, 32'd1500, 256, 256));
        // channel 1 hits the safety timeout exactly
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'd3601000, 256, 256));
        // start just before the timestamp wraps
        queue_pass(mk_pass(FUNC_START,  0, 0, 0, 32'hFFFF_FFF0, 256, 256));
        queue_pass(mk_pass(FUNC_START,  1, 0, 0, 32'hFFFF_FFF0, 256, 256));
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'h0000_0010, 100, 100));
        // both channels dry in one pass
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'h0000_0010, -32768, -32768));
        // both channels time out in one pass, one tick after the near miss
        queue_pass(mk_pass(FUNC_START,  0, 0, 0, 32'h100, 512, 512));
        queue_pass(mk_pass(FUNC_START,  1, 0, 0, 32'h100, 512, 512));
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'h100 + 32'd3599999, 512, 512));
        queue_pass(mk_pass(FUNC_NONE,   0, 0, 0, 32'h100 + 32'd3600000, 512, 512));
        queue_pass(mk_pass(FUNC_DUTY,   1, 0, 0,   32'h0037_0000, 512, 512));
        queue_pass(mk_pass(FUNC_DUTY,   1, 0, 101, 32'h0037_0001, 512, 512));
        wait_idle();

        // short timeout, random threshold and step
        set_config(32'd3000, int'($urandom_range(0, 512)) - 256, $urandom_range(1, 511));
        send_gap_max = 3;
        recv_gap_max = 3;
        queue_random(150);
        wait_idle();

        // zero timeout fires on the first pass; threshold never dry; slowest
        // ramp; no gaps so the long receiver hold-off backs up the input
        set_config(32'd0, -32768, 1);
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_random(130);
        wait_idle();

        // timeout never in practice, threshold at max, largest step
        set_config(32'hFFFF_FFFF, 32767, 511);
        send_gap_max = 3;
        recv_gap_max = 0;
        queue_random(100);
        wait_idle();

        // zero step freezes the duty
        set_config(32'd1500, 0, 0);
        write_reg(CFG_UNUSED, $urandom);
        send_gap_max = 0;
        recv_gap_max = 3;
        queue_random(100);
        wait_idle();

        // mid-range mix
        set_config($urandom_range(500, 8000), int'($urandom_range(0, 600)) - 300,
                   $urandom_range(1, 64));
        send_gap_max = 3;
        recv_gap_max = 3;
        queue_random(200);
        wait_idle();

        if (errors == 0 && status_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
design/dprhc_pkg.sv
design/dprhc_chan.sv
design/dual_pwm_ramp_heater_controller.sv
sim/tb.sv
